>>> design/smm_pkg.sv
`default_nettype none

package smm_pkg;

  // Size defaults for the top level
  localparam int MaxKDefault = 16;
  localparam int MaxNDefault = 16;

  // Field widths
  localparam int CfgW  = 5;
  localparam int IdxW  = 4;
  localparam int ValW  = 16;
  localparam int ProdW = 32;
  localparam int AccW  = 36;
  localparam int InDataW  = 24;
  localparam int OutDataW = 40;

  // Input kinds carried on tuser
  localparam logic CMD_B_WRITE = 1'b0;
  localparam logic CMD_A_FEED  = 1'b1;

  // Register indexes
  localparam logic REG_INNER_SIZE = 1'b0;
  localparam logic REG_OUT_COLS   = 1'b1;

  localparam logic [CfgW-1:0] CFG_RESET = 5'd16;

endpackage

`default_nettype wire

>>> design/streaming_matrix_multiply.sv
`default_nettype none

// Streaming fixed-point matrix multiply C = A x B. B (inner_size rows by
// out_cols columns, Q8.8) is loaded one entry per transfer with tuser low;
// rows of A then arrive one Q8.8 element per transfer with tuser high. Each
// A element is multiplied against its row of B by a single shared 16x16
// multiplier, one column per cycle, and added into per-column 36-bit Q20.16
// accumulators held in a small RAM. An A element is taken in one transfer,
// then issued through the multiply-accumulate pipe for each of its N columns
// (N = effective out_cols); the pipe then drains and writes the last column
// back. After the K-th element of a row the N sums are sent in column order,
// each read from the accumulator RAM (S_RD) and then offered (S_SEND), with
// tlast on column N-1; accumulators are then cleared at once through
// per-column valid bits. The input is not ready while an element or an
// output row is in progress. Out-of-range register values clamp to
// 1..MAX_K and 1..MAX_N; B writes outside the store are dropped. Reading a
// B entry never written returns an undefined value.
module streaming_matrix_multiply
  import smm_pkg::*;
#(
  parameter int MAX_K = MaxKDefault,
  parameter int MAX_N = MaxNDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic                cfg_addr_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,

  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [3:0] b_row, [7:4] b_col, [23:8] value
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] cmd
  input  wire logic                s_axis_tuser,

  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [35:0] sum_value, [39:36] col_index
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int NW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int AW = (MAX_K * MAX_N > 1) ? $clog2(MAX_K * MAX_N) : 1;
  localparam int Depth = MAX_K * MAX_N;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_FLUSH,
    S_RD,
    S_SEND
  } state_e;

  // Config registers
  logic [CfgW-1:0] inner_q, outcols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q   <= CFG_RESET;
      outcols_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_INNER_SIZE: inner_q   <= cfg_wdata_i;
        REG_OUT_COLS:   outcols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamped sizes
  logic [31:0] eff_k, eff_n;
  logic [NW-1:0] n_m1;

  always_comb begin
    if (inner_q == '0) eff_k = 32'd1;
    else if ({27'b0, inner_q} > 32'(MAX_K)) eff_k = 32'(MAX_K);
    else eff_k = {27'b0, inner_q};
    if (outcols_q == '0) eff_n = 32'd1;
    else if ({27'b0, outcols_q} > 32'(MAX_N)) eff_n = 32'(MAX_N);
    else eff_n = {27'b0, outcols_q};
  end

  assign n_m1 = NW'(eff_n - 32'd1);

  // Input unpacking
  logic [IdxW-1:0] in_row, in_col;
  logic [ValW-1:0] in_val;
  logic            in_hs;

  assign in_row = s_axis_tdata[3:0];
  assign in_col = s_axis_tdata[7:4];
  assign in_val = s_axis_tdata[23:8];
  assign in_hs  = s_axis_tvalid && s_axis_tready;

  // Sequencer state
  state_e          state_q;
  logic [NW-1:0]   j_q;
  logic [KW-1:0]   elem_q;
  logic [MAX_N-1:0] acc_vld_q;
  logic            p1_q, p2_q;
  logic [NW-1:0]   p1_idx_q, p2_idx_q;
  logic            out_hs, is_last, row_end;

  assign is_last = (j_q == n_m1);
  assign row_end = ((32'(elem_q) + 32'd1) >= eff_k);
  assign out_hs  = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_SEND);

  // Memory port controls
  logic          mac_issue, acc_rd_en, w_wr_en;
  logic [AW-1:0] w_rd_addr, w_wr_addr;

  assign mac_issue = (state_q == S_MAC);
  assign acc_rd_en = mac_issue || (state_q == S_RD);
  assign w_rd_addr = AW'(32'(elem_q) * 32'(MAX_N) + 32'(j_q));
  assign w_wr_addr = AW'(32'(in_row) * 32'(MAX_N) + 32'(in_col));
  assign w_wr_en   = in_hs && (s_axis_tuser == CMD_B_WRITE) &&
                     (32'(in_row) < 32'(MAX_K)) && (32'(in_col) < 32'(MAX_N));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      j_q       <= '0;
      elem_q    <= '0;
      acc_vld_q <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      p1_idx_q  <= '0;
      p2_idx_q  <= '0;
    end else begin
      p1_q     <= mac_issue;
      p1_idx_q <= j_q;
      p2_q     <= p1_q;
      p2_idx_q <= p1_idx_q;
      if (p2_q) acc_vld_q[p2_idx_q] <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (in_hs && (s_axis_tuser == CMD_A_FEED)) begin
            j_q     <= '0;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          if (is_last) state_q <= S_FLUSH;
          else j_q <= j_q + 1'b1;
        end
        S_FLUSH: begin
          // wait for the last column to be written back
          if (!p1_q && !p2_q) begin
            j_q <= '0;
            if (row_end) begin
              state_q <= S_RD;
            end else begin
              elem_q  <= elem_q + 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_RD: state_q <= S_SEND;
        S_SEND: begin
          if (out_hs) begin
            if (is_last) begin
              acc_vld_q <= '0;
              elem_q    <= '0;
              state_q   <= S_IDLE;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // B store, one write and one registered read port
  logic [ValW-1:0] w_mem [Depth];
  logic [ValW-1:0] w_rd_q;

  always_ff @(posedge clk_i) begin
    if (w_wr_en) w_mem[w_wr_addr] <= in_val;
    if (mac_issue) w_rd_q <= w_mem[w_rd_addr];
  end

  // Accumulator RAM, masked by the valid bits
  logic [AccW-1:0] acc_mem [MAX_N];
  logic [AccW-1:0] acc_rd_q, p2_acc_q;
  logic            acc_hit_q;
  logic signed [ValW-1:0]  a_q;
  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (in_hs) a_q <= in_val;
    if (acc_rd_en) begin
      acc_rd_q  <= acc_mem[j_q];
      acc_hit_q <= acc_vld_q[j_q];
    end
    prod_q   <= a_q * $signed(w_rd_q);
    p2_acc_q <= acc_hit_q ? acc_rd_q : '0;
    if (p2_q) acc_mem[p2_idx_q] <= p2_acc_q + AccW'(prod_q);
  end

  // Result straight from the registered read, held while stalled
  logic [AccW-1:0] sum_out;

  assign sum_out       = acc_hit_q ? acc_rd_q : '0;
  assign m_axis_tdata  = {IdxW'(j_q), sum_out};
  assign m_axis_tlast  = is_last;

  // Checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && m_axis_tlast |=> (acc_vld_q == '0) && (elem_q == '0))
    else $error("accumulators not cleared after row");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && !m_axis_tlast |=> (j_q == $past(j_q) + 1'b1))
    else $error("column index did not advance");

  a_feed_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs && (s_axis_tuser == CMD_A_FEED) |=> (state_q == S_MAC) && (j_q == '0))
    else $error("A element did not start the accumulate pass");

  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !p2_q)
    else $error("write-back pending while idle");

endmodule

`default_nettype wire

>>> tb/smm_row_checker.sv
`default_nettype none

// Watches the config port and both stream channels, keeps its own copy of B,
// the column accumulators and the element position, and checks each result
// transfer against the oldest predicted row entry.
module smm_row_checker
  import smm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_addr_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tuser,
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [OutDataW-1:0] m_axis_tdata,
  input  wire logic                m_axis_tlast,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct {
    logic signed [AccW-1:0] sum;
    logic [IdxW-1:0]        col;
    logic                   last;
  } row_sum_t;

  logic signed [ValW-1:0] weight_mem [MaxKDefault][MaxNDefault];
  logic [AccW-1:0]        col_acc [MaxNDefault];
  int unsigned            elem_idx;
  logic [CfgW-1:0]        inner_reg;
  logic [CfgW-1:0]        cols_reg;
  row_sum_t               row_sums_q [$];

  // register value to the dimension it stands for (0 -> 1, clamp at top)
  function automatic int unsigned dim_of(logic [CfgW-1:0] raw, int unsigned max_dim);
    if (raw == '0) return 1;
    if (raw > max_dim) return max_dim;
    return raw;
  endfunction

  task automatic feed_element(logic signed [ValW-1:0] a);
    int unsigned             k_len;
    int unsigned             n_cols;
    logic signed [ProdW-1:0] prod;
    row_sum_t                entry;
    k_len  = dim_of(inner_reg, MaxKDefault);
    n_cols = dim_of(cols_reg, MaxNDefault);
    for (int unsigned j = 0; j < n_cols; j++) begin
      prod       = a * weight_mem[elem_idx][j];
      col_acc[j] = col_acc[j] + AccW'(prod);
    end
    if (elem_idx + 1 >= k_len) begin
      for (int unsigned j = 0; j < n_cols; j++) begin
        entry.sum  = col_acc[j];
        entry.col  = IdxW'(j);
        entry.last = (j + 1 == n_cols);
        row_sums_q = {row_sums_q, entry};
      end
      for (int j = 0; j < MaxNDefault; j++) col_acc[j] = '0;
      elem_idx = 0;
    end else begin
      elem_idx++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_sum_t               want;
    logic signed [AccW-1:0] got_sum;
    logic [IdxW-1:0]        got_col;
    if (!rst_ni) begin
      for (int r = 0; r < MaxKDefault; r++)
        for (int c = 0; c < MaxNDefault; c++) weight_mem[r][c] = '0;
      for (int j = 0; j < MaxNDefault; j++) col_acc[j] = '0;
      elem_idx     = 0;
      inner_reg    = CFG_RESET;
      cols_reg     = CFG_RESET;
      row_sums_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_INNER_SIZE) inner_reg = cfg_wdata_i;
        else cols_reg = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_A_FEED) begin
          feed_element(s_axis_tdata[2*IdxW +: ValW]);
        end else begin
          weight_mem[s_axis_tdata[0 +: IdxW]][s_axis_tdata[IdxW +: IdxW]] =
            s_axis_tdata[2*IdxW +: ValW];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_sum = m_axis_tdata[0 +: AccW];
        got_col = m_axis_tdata[AccW +: IdxW];
        if (row_sums_q.size() == 0) begin
          $error("unexpected result: col_index %0d sum_value %0d", got_col, got_sum);
          fail_count_o++;
        end else begin
          want = row_sums_q.pop_front();
          if (got_sum !== want.sum) begin
            $error("sum_value: expected %0d, got %0d", want.sum, got_sum);
            fail_count_o++;
          end
          if (got_col !== want.col) begin
            $error("col_index: expected %0d, got %0d", want.col, got_col);
            fail_count_o++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            fail_count_o++;
          end
        end
      end
      pending_o = row_sums_q.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/streaming_matrix_multiply_tb.sv
`default_nettype none

// Stimulus and verdict for the streaming matrix multiply. The row checker
// sitting beside the block does all prediction and comparison.
module streaming_matrix_multiply_tb;
  import smm_pkg::*;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int StallLimit     = 5000;
  // one long sink hold-off, long enough to back the block up
  localparam int SinkHoldCycles = 300;
  // quiet time after the last result: covers an element still in the MAC
  // pipe before a register write or the verdict
  localparam int SettleCycles   = 40;
  localparam int NumShapes      = 7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_addr_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int                  fail_count;
  int                  pending_sums;
  int unsigned         stall_cycles = 0;
  bit                  sink_hold_req = 1'b0;

  // Stimulus-side bookkeeping so that no A element ever reads a B entry
  // that was never loaded: which entries hold data, the effective K and N,
  // and the position of the next A element within its row.
  bit                  b_loaded [MaxKDefault][MaxNDefault];
  int unsigned         k_eff = MaxKDefault;
  int unsigned         n_eff = MaxNDefault;
  int unsigned         a_pos = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  streaming_matrix_multiply u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  smm_row_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending_sums)
  );

  // mostly back-to-back, often a short gap, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Q8.8 operand, biased towards the extremes and zero
  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return ValW'($urandom);
    endcase
  endfunction

  function automatic int unsigned dim_of(logic [CfgW-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MaxKDefault) return MaxKDefault;
    return raw;
  endfunction

  // One input transfer. Called and returns at a falling edge; valid stays
  // high into the next item when no gap is drawn.
  task automatic offer(logic cmd, logic [IdxW-1:0] row, logic [IdxW-1:0] col,
                       logic [ValW-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {val, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic load_weight(int unsigned row, int unsigned col, logic [ValW-1:0] val);
    offer(CMD_B_WRITE, IdxW'(row), IdxW'(col), val);
    b_loaded[row][col] = 1'b1;
  endtask

  // Next A element; any B entry this element will read that is still empty
  // gets a random value first. Row/col bits are don't-care here, so random.
  task automatic feed_a(logic [ValW-1:0] val);
    for (int unsigned j = 0; j < n_eff; j++)
      if (!b_loaded[a_pos][j]) load_weight(a_pos, j, pick_value());
    offer(CMD_A_FEED, IdxW'($urandom), IdxW'($urandom), val);
    a_pos = (a_pos + 1 >= k_eff) ? 0 : a_pos + 1;
  endtask

  // Sender stops and waits for every predicted result, then lets the MAC
  // pipe drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_sums != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [CfgW-1:0] raw);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= raw;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    if (addr == REG_INNER_SIZE) k_eff = dim_of(raw);
    else n_eff = dim_of(raw);
  endtask

  task automatic set_shape(logic [CfgW-1:0] k_raw, logic [CfgW-1:0] n_raw);
    settle();
    write_reg(REG_INNER_SIZE, k_raw);
    write_reg(REG_OUT_COLS, n_raw);
  endtask

  // Random traffic: mostly A elements forming whole rows, some B rewrites
  // landing anywhere in the store.
  task automatic random_rows(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        load_weight($urandom_range(0, 15), $urandom_range(0, 15), pick_value());
      else
        feed_a(pick_value());
    end
  endtask

  // Stimulus and verdict
  initial begin
    logic [CfgW-1:0] shape_k [NumShapes];
    logic [CfgW-1:0] shape_n [NumShapes];
    int unsigned     shape_items [NumShapes];
    shape_k     = '{5'd4, 5'd1, 5'd7, 5'd3, 5'd16, 5'd2, 5'd5};
    shape_n     = '{5'd3, 5'd1, 5'd6, 5'd5, 5'd1, 5'd9, 5'd4};
    shape_items = '{8, 5, 8, 6, 12, 6, 6};

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_INNER_SIZE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = CMD_B_WRITE;
    s_axis_tdata  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 2x3 B with extreme operands, two rows of A
    set_shape(5'd2, 5'd3);
    load_weight(0, 0, 16'h7fff);
    load_weight(0, 1, 16'h8000);
    load_weight(0, 2, 16'h0000);
    load_weight(1, 0, 16'hffff);
    load_weight(1, 1, 16'h0100);
    load_weight(1, 2, 16'h8000);
    feed_a(16'h8000);
    feed_a(16'h7fff);
    feed_a(16'h0000);
    feed_a(16'h8000);

    // shape changed with a row half done: K drops below the position, N grows
    // so column 2 reports only what this last element adds
    set_shape(5'd3, 5'd2);
    feed_a(16'h0100);
    set_shape(5'd1, 5'd3);
    feed_a(16'hff00);

    // out-of-range register codes: zero acts as 1, large clamps to 16
    set_shape(5'd0, 5'd31);
    feed_a(16'h7fff);
    set_shape(5'd31, 5'd0);
    feed_a(16'h8000);
    feed_a(16'hffff);

    // random part; the sink takes its long hold-off early on
    for (int s = 0; s < NumShapes; s++) begin
      set_shape(shape_k[s], shape_n[s]);
      if (s == 0) sink_hold_req = 1'b1;
      random_rows(shape_items[s]);
    end

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Sink: random ready pattern, plus one long hold-off on request
  initial begin
    int unsigned gap;
    int unsigned burst;
    bit          held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_req && !held) begin
        held = 1'b1;
        repeat (SinkHoldCycles) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end
      gap   = pick_gap();
      burst = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      repeat (burst) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

`default_nettype wire
